@@ rtl/teq_pkg.sv @@
// Shared constants and types for the time-ordered event queue.
package teq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TIME_BITS   = 32;
  localparam int KIND_BITS   = 3;
  localparam int TAG_BITS    = 16;
  localparam int ADDR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_PURGE  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [TIME_BITS-1:0] etime;
    logic [KIND_BITS-1:0] kind;
    logic [TAG_BITS-1:0]  tag;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

endpackage

@@ rtl/time_ordered_event_queue.sv @@
// Time-ordered event queue: sorted event store in one RAM with a walking sequencer.
//
// Usage: present operation, event_time, event_kind and event_tag with start
// high while busy is low; that edge is the transfer. Operations: insert,
// pop earliest, remove first entry at a time, remove all entries of a kind.
// Exactly one result follows each transfer: done is high for one cycle with
// status, out_time, out_kind, out_tag, removed_count and occupancy valid.
// The receiver cannot stall; the result must be taken in that cycle.
//
// Refused or trivial operations on an empty or full queue give their
// result in the cycle after the transfer. Insert walks down from the
// tail one entry per cycle, shifting entries up. Pop, remove and purge
// compact the store in one pass over all entries, one per cycle through
// the single RAM read port.
// Reset empties the queue at once; the RAM contents are not cleared.
module time_ordered_event_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation,
  input  logic [teq_pkg::TIME_BITS-1:0] event_time,
  input  logic [teq_pkg::KIND_BITS-1:0] event_kind,
  input  logic [teq_pkg::TAG_BITS-1:0]  event_tag,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [teq_pkg::TIME_BITS-1:0] out_time,
  output logic [teq_pkg::KIND_BITS-1:0] out_kind,
  output logic [teq_pkg::TAG_BITS-1:0]  out_tag,
  output logic [teq_pkg::CNT_BITS-1:0]  removed_count,
  output logic [teq_pkg::CNT_BITS-1:0]  occupancy
);
  import teq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_PUT  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;

  logic [2:0]           state, state_next;
  logic [1:0]           op, op_next;
  entry_t               item, item_next;
  logic [CNT_BITS-1:0]  count, count_next;
  logic [ADDR_BITS-1:0] idx, idx_next;
  logic [ADDR_BITS-1:0] wp, wp_next;
  logic                 ge0, ge0_next;
  logic                 found, found_next;
  logic [CNT_BITS-1:0]  rmv, rmv_next;
  entry_t               cap, cap_next;

  logic                 we;
  logic [ADDR_BITS-1:0] waddr, raddr;
  entry_t               wdata, rd;
  logic                 fin;
  logic [1:0]           fin_status;
  logic [CNT_BITS-1:0]  cnt_m1;
  logic [ADDR_BITS-1:0] last;
  logic                 del;

  teq_ram #(.WIDTH(ENTRY_BITS), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd)
  );

  assign cnt_m1 = count - CNT_BITS'(1);
  assign last   = cnt_m1[ADDR_BITS-1:0];
  assign busy   = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op_next    = op;
    item_next  = item;
    count_next = count;
    idx_next   = idx;
    wp_next    = wp;
    ge0_next   = ge0;
    found_next = found;
    rmv_next   = rmv;
    cap_next   = cap;
    we         = 1'b0;
    waddr      = '0;
    wdata      = item;
    raddr      = idx;
    fin        = 1'b0;
    fin_status = ST_OK;
    del        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next    = operation;
          item_next  = '{etime: event_time, kind: event_kind, tag: event_tag};
          cap_next   = '0;
          rmv_next   = '0;
          found_next = 1'b0;
          idx_next   = '0;
          wp_next    = '0;
          raddr      = '0;
          if (operation == OP_INSERT) begin
            if (count == CNT_BITS'(QUEUE_DEPTH)) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else if (count == '0) begin
              we         = 1'b1;
              wdata      = item_next;
              count_next = CNT_BITS'(1);
              fin        = 1'b1;
            end else begin
              state_next = S_HEAD;
            end
          end else begin
            if (count == '0) begin
              fin        = 1'b1;
              fin_status = ST_MISS;
            end else begin
              state_next = S_CMP;
            end
          end
        end
      end
      S_HEAD: begin
        ge0_next   = (rd.etime >= item.etime);
        idx_next   = last;
        raddr      = last;
        state_next = S_INS;
      end
      S_INS: begin
        // walk down from the tail, moving later entries up one slot
        if (idx == last && rd.etime <= item.etime && !ge0) begin
          we         = 1'b1;
          waddr      = count[ADDR_BITS-1:0];
          count_next = count + CNT_BITS'(1);
          fin        = 1'b1;
          state_next = S_IDLE;
        end else if (rd.etime >= item.etime) begin
          we    = 1'b1;
          waddr = idx + ADDR_BITS'(1);
          wdata = rd;
          if (idx == '0) begin
            state_next = S_PUT;
          end else begin
            idx_next = idx - ADDR_BITS'(1);
            raddr    = idx - ADDR_BITS'(1);
          end
        end else begin
          we         = 1'b1;
          waddr      = idx + ADDR_BITS'(1);
          count_next = count + CNT_BITS'(1);
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_PUT: begin
        we         = 1'b1;
        waddr      = '0;
        count_next = count + CNT_BITS'(1);
        fin        = 1'b1;
        state_next = S_IDLE;
      end
      S_CMP: begin
        // compaction pass: keep survivors, pack them toward slot 0
        unique case (op)
          OP_POP:    del = (idx == '0);
          OP_REMOVE: del = !found && (rd.etime == item.etime);
          OP_PURGE:  del = (rd.kind == item.kind);
          default:   del = 1'b0;
        endcase
        if (del) begin
          rmv_next = rmv + CNT_BITS'(1);
          if (!found && op != OP_PURGE) begin
            cap_next   = rd;
            found_next = 1'b1;
          end
        end else begin
          we      = 1'b1;
          waddr   = wp;
          wdata   = rd;
          wp_next = wp + ADDR_BITS'(1);
        end
        if (idx == last) begin
          count_next = count - rmv_next;
          fin        = 1'b1;
          fin_status = (rmv_next == '0) ? ST_MISS : ST_OK;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + ADDR_BITS'(1);
          raddr    = idx + ADDR_BITS'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= fin;
    end
    op    <= op_next;
    item  <= item_next;
    idx   <= idx_next;
    wp    <= wp_next;
    ge0   <= ge0_next;
    found <= found_next;
    rmv   <= rmv_next;
    cap   <= cap_next;
    if (fin) begin
      status        <= fin_status;
      out_time      <= cap_next.etime;
      out_kind      <= cap_next.kind;
      out_tag       <= cap_next.tag;
      removed_count <= rmv_next;
      occupancy     <= count_next;
    end
  end

endmodule

@@ rtl/teq_ram.sv @@
// Generic simple dual-port RAM with registered read.
module teq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/teq_checker.sv @@
// Port-level checks for the event queue, bound to the top level.
module teq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [1:0]                    status,
  input logic [teq_pkg::CNT_BITS-1:0]  removed_count,
  input logic [teq_pkg::CNT_BITS-1:0]  occupancy
);
  import teq_pkg::*;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");

  a_transfer_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done)) else $error("transfer dropped");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (occupancy <= CNT_BITS'(QUEUE_DEPTH))) else $error("occupancy overflow");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (occupancy == CNT_BITS'(QUEUE_DEPTH)
      && removed_count == '0)) else $error("full status while not full");

endmodule

bind time_ordered_event_queue teq_checker u_teq_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .removed_count (removed_count),
  .occupancy     (occupancy)
);

@@ tb/tb.sv @@
// Self-checking testbench for the time-ordered event queue.
module tb;
  import teq_pkg::*;

  typedef struct packed {
    logic [1:0]          status;
    logic [TIME_BITS-1:0] etime;
    logic [KIND_BITS-1:0] kind;
    logic [TAG_BITS-1:0]  tag;
    logic [CNT_BITS-1:0]  removed;
    logic [CNT_BITS-1:0]  occ;
  } outcome_t;

  class queue_scoreboard;
    entry_t   held[$];
    outcome_t pending[$];
    int       mismatches;
    int       checked;

    function void note_transfer(logic [1:0] op, logic [TIME_BITS-1:0] t,
                                logic [KIND_BITS-1:0] k, logic [TAG_BITS-1:0] g);
      outcome_t o;
      entry_t   e;
      entry_t   kept[$];
      int       p;
      o = '{ST_OK, '0, '0, '0, '0, '0};
      case (op)
        OP_INSERT: begin
          if (held.size() >= QUEUE_DEPTH) begin
            o.status = ST_FULL;
          end else begin
            e = '{t, k, g};
            if (held.size() == 0 || held[0].etime >= t) p = 0;
            else if (held[held.size()-1].etime <= t) p = held.size();
            else begin
              p = 0;
              while (held[p].etime < t) p++;
            end
            held.insert(p, e);
          end
        end
        OP_POP, OP_REMOVE: begin
          p = 0;
          if (op == OP_REMOVE)
            while (p < held.size() && held[p].etime != t) p++;
          if (p >= held.size()) begin
            o.status = ST_MISS;
          end else begin
            o.etime = held[p].etime;
            o.kind = held[p].kind;
            o.tag = held[p].tag;
            o.removed = CNT_BITS'(1);
            held.delete(p);
          end
        end
        default: begin
          foreach (held[i])
            if (held[i].kind == k) o.removed++;
            else kept.push_back(held[i]);
          held = kept;
          if (o.removed == 0) o.status = ST_MISS;
        end
      endcase
      o.occ = CNT_BITS'(held.size());
      pending.push_back(o);
    endfunction

    function void check_result(outcome_t got);
      outcome_t x;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", got.status);
        return;
      end
      x = pending.pop_front();
      if (got !== x) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result %0d: exp st=%0d t=%h k=%0d g=%h rm=%0d occ=%0d,",
                    " got st=%0d t=%h k=%0d g=%h rm=%0d occ=%0d"},
                   checked, x.status, x.etime, x.kind, x.tag, x.removed, x.occ,
                   got.status, got.etime, got.kind, got.tag, got.removed, got.occ);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [1:0] operation = '0;
  logic [TIME_BITS-1:0] event_time = '0;
  logic [KIND_BITS-1:0] event_kind = '0;
  logic [TAG_BITS-1:0] event_tag = '0;
  logic done;
  logic [1:0] status;
  logic [TIME_BITS-1:0] out_time;
  logic [KIND_BITS-1:0] out_kind;
  logic [TAG_BITS-1:0] out_tag;
  logic [CNT_BITS-1:0] removed_count, occupancy;

  queue_scoreboard sb = new();
  int cycles = 0;
  int n_insert = 0, n_full = 0, n_miss = 0;
  logic [TIME_BITS-1:0] recent_time = '0;

  always #5 clk = ~clk;

  time_ordered_event_queue u_dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (status == ST_FULL) n_full++;
      if (status == ST_MISS) n_miss++;
      sb.check_result('{status, out_time, out_kind, out_tag, removed_count, occupancy});
    end
    if (cycles > 2000000) begin
      $display("timeout");
      $display("end of test: mismatches");
      $finish;
    end
  end

  // One transfer; start stays high until the edge where busy is low.
  // With no gap start stays high into the next transfer.
  task automatic issue(logic [1:0] op, logic [TIME_BITS-1:0] t,
                       logic [KIND_BITS-1:0] k, logic [TAG_BITS-1:0] g, int gap);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    operation <= op;
    event_time <= t;
    event_kind <= k;
    event_tag <= g;
    do @(posedge clk); while (busy);
    sb.note_transfer(op, t, k, g);
    if (op == OP_INSERT) begin
      n_insert++;
      recent_time = t;
    end
  endtask

  // Times cluster in a narrow window so equal times and remove hits are common.
  function automatic logic [TIME_BITS-1:0] pick_time();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return recent_time;
      2: return {TIME_BITS{1'b1}} - $urandom_range(0, 3);
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
  endfunction

  initial begin
    int fill;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty pop/remove/purge, extremes, front/back/middle insert.
    issue(OP_POP, '0, '0, '0, 0);
    issue(OP_REMOVE, 5, '0, '0, 0);
    issue(OP_PURGE, '0, 3'd7, '0, 0);
    issue(OP_INSERT, 100, 3'd1, 16'h0001, 0);
    issue(OP_INSERT, 100, 3'd2, 16'h0002, 0);
    issue(OP_INSERT, {TIME_BITS{1'b1}}, 3'd7, 16'hFFFF, 0);
    issue(OP_INSERT, {TIME_BITS{1'b1}}, 3'd0, 16'h8000, 1);
    issue(OP_INSERT, '0, 3'd0, 16'h0000, 0);
    issue(OP_INSERT, 500, 3'd5, 16'h5555, 2);
    issue(OP_INSERT, 100, 3'd2, 16'hAAAA, 0);
    issue(OP_REMOVE, 500, '0, '0, 0);
    issue(OP_REMOVE, 12345, '0, '0, 0);
    issue(OP_REMOVE, {TIME_BITS{1'b1}}, '0, '0, 0);
    issue(OP_PURGE, '0, 3'd2, '0, 0);
    issue(OP_PURGE, '0, 3'd6, '0, 0);
    issue(OP_POP, '0, '0, '0, 0);
    issue(OP_POP, '0, '0, '0, 0);
    issue(OP_POP, '0, '0, '0, 0);
    issue(OP_POP, '0, '0, '0, 0);

    // Fill to capacity, then refuse an insert.
    for (fill = 0; fill < QUEUE_DEPTH; fill++)
      issue(OP_INSERT, pick_time(), KIND_BITS'($urandom()), TAG_BITS'($urandom()), 0);
    issue(OP_INSERT, 7, 3'd3, 16'h1234, 0);

    // Random phases: insert-heavy to run full, drain-heavy to hit empty.
    for (int i = 0; i < 2000; i++) begin
      int bias, r;
      logic [1:0] op;
      bias = ((i / 150) % 2 == 0) ? 60 : 25;
      r = $urandom_range(0, 99);
      if (r < bias) op = OP_INSERT;
      else if (r < bias + (100 - bias) / 2) op = OP_POP;
      else if (r < 92) op = OP_REMOVE;
      else op = OP_PURGE;
      issue(op, pick_time(), KIND_BITS'($urandom()), TAG_BITS'($urandom()), pick_gap());
    end
    start <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("ran %0d inserts among %0d results; %0d refused full, %0d empty or missed",
             n_insert, sb.checked, n_full, n_miss);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
